>>> rtl/mtwm_pkg.sv
// package for the markup text width measure block
// holds utf-8 and markup byte codes and the decoder state type; no dependencies
package mtwm_pkg;

	// utf-8 lead and continuation masks and patterns
	localparam logic [7:0] MASK_E0 = 8'hE0;
	localparam logic [7:0] MASK_F0 = 8'hF0;
	localparam logic [7:0] MASK_F8 = 8'hF8;
	localparam logic [7:0] MASK_FC = 8'hFC;
	localparam logic [7:0] MASK_FE = 8'hFE;
	localparam logic [7:0] MASK_C0 = 8'hC0;
	localparam logic [7:0] LEAD_2 = 8'hC0;
	localparam logic [7:0] LEAD_3 = 8'hE0;
	localparam logic [7:0] LEAD_4 = 8'hF0;
	localparam logic [7:0] LEAD_5 = 8'hF8;
	localparam logic [7:0] LEAD_6 = 8'hFC;
	localparam logic [7:0] CONT_PAT = 8'h80;

	// markup characters
	localparam logic [7:0] CH_TILDE = 8'h7E;
	localparam logic [7:0] CH_LT = 8'h3C;
	localparam logic [7:0] CH_GT = 8'h3E;
	localparam logic [7:0] CH_BANG = 8'h21;

	// first code point that has a glyph table entry
	localparam int unsigned GLYPH_BASE = 32;

	// input opcodes
	localparam logic OP_TEXT = 1'b0;
	localparam logic OP_TABLE = 1'b1;

	localparam int CODE_BITS = 31;

	typedef struct packed {
		logic [2:0] rem;
		logic [CODE_BITS-1:0] accum;
		logic tilde;
		logic hidden;
		logic halted;
	} dec_state_t;

	typedef struct packed {
		logic add;
		logic [CODE_BITS-1:0] code;
	} glyph_req_t;

endpackage

>>> rtl/mtwm_decode.sv
// utf-8 and tilde markup decoder: next decode state and glyph request per byte
// depends on mtwm_pkg
module mtwm_decode import mtwm_pkg::*; (
	input dec_state_t cur,
	input logic [7:0] data_byte,
	input logic last_byte,
	input logic plain_mode,
	output dec_state_t nxt,
	output glyph_req_t req
);

	logic run_dec;
	logic done;
	logic [CODE_BITS-1:0] done_code;
	logic [CODE_BITS-1:0] acc_new;

	assign acc_new = {cur.accum[CODE_BITS-7:0], data_byte[5:0]};

	always_comb begin
		nxt = cur;
		req = '0;
		run_dec = 1'b0;
		done = 1'b0;
		done_code = '0;

		// escape resolution
		if (!cur.halted) begin
			if (cur.tilde) begin
				nxt.tilde = 1'b0;
				if (data_byte inside {CH_LT, CH_GT}) begin
					nxt.hidden = 1'b0;
				end else if (data_byte == CH_BANG) begin
					nxt.hidden = cur.hidden;
				end else if (data_byte == CH_TILDE) begin
					req.add = !cur.hidden;
					req.code = CODE_BITS'(CH_TILDE);
				end else begin
					nxt.hidden = !cur.hidden;
					run_dec = 1'b1;
				end
			end else begin
				run_dec = 1'b1;
			end
		end

		// utf-8 decode
		if (run_dec) begin
			if (cur.rem == 3'd0) begin
				if (!data_byte[7]) begin
					done = 1'b1;
					done_code = CODE_BITS'(data_byte);
				end else if ((data_byte & MASK_E0) == LEAD_2) begin
					nxt.accum = CODE_BITS'(data_byte[4:0]);
					nxt.rem = 3'd1;
				end else if ((data_byte & MASK_F0) == LEAD_3) begin
					nxt.accum = CODE_BITS'(data_byte[3:0]);
					nxt.rem = 3'd2;
				end else if ((data_byte & MASK_F8) == LEAD_4) begin
					nxt.accum = CODE_BITS'(data_byte[2:0]);
					nxt.rem = 3'd3;
				end else if ((data_byte & MASK_FC) == LEAD_5) begin
					nxt.accum = CODE_BITS'(data_byte[1:0]);
					nxt.rem = 3'd4;
				end else if ((data_byte & MASK_FE) == LEAD_6) begin
					nxt.accum = CODE_BITS'(data_byte[0]);
					nxt.rem = 3'd5;
				end else begin
					nxt.halted = 1'b1;
				end
			end else if ((data_byte & MASK_C0) != CONT_PAT) begin
				nxt.halted = 1'b1;
			end else begin
				nxt.accum = acc_new;
				nxt.rem = cur.rem - 3'd1;
				if (cur.rem == 3'd1) begin
					done = 1'b1;
					done_code = acc_new;
				end
			end
		end

		// finished character
		if (done) begin
			if (done_code == CODE_BITS'(CH_TILDE) && !plain_mode) begin
				if (last_byte) begin
					nxt.halted = 1'b1;
				end else begin
					nxt.tilde = 1'b1;
				end
			end else begin
				req.add = !nxt.hidden;
				req.code = done_code;
			end
		end
	end

endmodule

>>> rtl/markup_text_width_measure_core.sv
// markup text width measure: utf-8 / tilde markup decode with glyph width sum
// depends on mtwm_pkg and mtwm_decode
// throughput one byte or table write per cycle while in_stall is low; after its last
// byte is accepted it passes stage 1 and the result register, held while out_stall is high
// reset clears decode state, width sum and mode; the glyph table is not cleared
// the glyph table has one write port and one read port; each input uses at most one
module markup_text_width_measure_core import mtwm_pkg::*; #(
	parameter int GLYPH_COUNT = 256,
	parameter int SUM_BITS = 20
) (
	input logic clk,
	input logic arst_n,
	// configuration
	input logic cfg_wr_en,
	input logic cfg_wr_data,
	// input channel
	input logic in_valid,
	output logic in_stall,
	input logic opcode,
	input logic [7:0] data_byte,
	input logic last_byte,
	input logic [7:0] table_index,
	input logic [6:0] table_width,
	// result channel
	output logic out_valid,
	input logic out_stall,
	output logic [SUM_BITS-1:0] text_width
);

	localparam int AW = (GLYPH_COUNT > 1) ? $clog2(GLYPH_COUNT) : 1;

	// plain mode register
	logic plain_q;

	// decode state, updated when a text byte is accepted
	dec_state_t dec_q;
	dec_state_t dec_nxt;
	glyph_req_t req;

	// glyph width table, one synchronous port each way
	logic [6:0] glyph_mem [GLYPH_COUNT];

	// stage 1: table read data plus control
	logic valid_s1;
	logic add_s1;
	logic last_s1;
	logic [6:0] gw_s1;

	// accumulator and result register
	logic [SUM_BITS-1:0] width_q;
	logic out_valid_q;
	logic [SUM_BITS-1:0] out_width_q;

	logic in_accept;
	logic text_accept;
	logic adv_s1;
	logic [CODE_BITS-1:0] code_off;
	logic code_in_range;
	logic [AW-1:0] rd_addr;
	logic tbl_wr;
	logic [SUM_BITS:0] sum_raw;
	logic [SUM_BITS-1:0] sum_sat;
	logic [SUM_BITS-1:0] acc_val;

	mtwm_decode u_decode (
		.cur(dec_q),
		.data_byte(data_byte),
		.last_byte(last_byte),
		.plain_mode(plain_q),
		.nxt(dec_nxt),
		.req(req)
	);

	// a last byte in stage 1 waits only for the result register to free up
	assign adv_s1 = valid_s1 && !(last_s1 && out_valid_q && out_stall);
	assign in_stall = valid_s1 && !adv_s1;
	assign in_accept = in_valid && !in_stall;
	assign text_accept = in_accept && (opcode == OP_TEXT);

	// code to table entry; codes below the base or past the table use entry 0
	assign code_off = req.code - CODE_BITS'(GLYPH_BASE);
	assign code_in_range = (req.code >= CODE_BITS'(GLYPH_BASE))
		&& (32'(code_off) < 32'(GLYPH_COUNT));
	assign rd_addr = code_in_range ? AW'(code_off) : '0;

	// writes beyond the table are dropped
	assign tbl_wr = in_accept && (opcode == OP_TABLE)
		&& (32'(table_index) < 32'(GLYPH_COUNT));

	always_ff @(posedge clk) begin
		if (tbl_wr) begin
			glyph_mem[AW'(table_index)] <= table_width;
		end
	end

	// table writes land before any later read, so no forwarding is needed
	always_ff @(posedge clk) begin
		if (text_accept && req.add) begin
			gw_s1 <= glyph_mem[rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			plain_q <= 1'b0;
		end else if (cfg_wr_en) begin
			plain_q <= cfg_wr_data;
		end
	end

	// decode state; a last byte clears all string state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dec_q <= '0;
		end else if (text_accept) begin
			dec_q <= last_byte ? '0 : dec_nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			add_s1 <= 1'b0;
			last_s1 <= 1'b0;
		end else if (text_accept) begin
			valid_s1 <= 1'b1;
			add_s1 <= req.add;
			last_s1 <= last_byte;
		end else if (adv_s1) begin
			valid_s1 <= 1'b0;
		end
	end

	// glyph width plus one, saturating
	assign sum_raw = {1'b0, width_q} + (SUM_BITS+1)'(gw_s1) + (SUM_BITS+1)'(1);
	assign sum_sat = sum_raw[SUM_BITS] ? '1 : sum_raw[SUM_BITS-1:0];
	assign acc_val = add_s1 ? sum_sat : width_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q <= '0;
		end else if (adv_s1) begin
			width_q <= last_s1 ? '0 : acc_val;
		end
	end

	// result register: holds a finished transaction while the sink stalls
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv_s1 && last_s1) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1 && last_s1) begin
			out_width_q <= acc_val;
		end
	end

	assign out_valid = out_valid_q;
	assign text_width = out_width_q;

endmodule
